[rtl/voxel_center_of_mass_tracker_assert.svh]
// assertion macros for the center of mass tracker checker
// no dependencies
`ifndef VOXEL_CENTER_OF_MASS_TRACKER_ASSERT_SVH
`define VOXEL_CENTER_OF_MASS_TRACKER_ASSERT_SVH
// implication checked on every clock, off during reset
`define VCM_ASSERT_IMP(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("assertion failed");
// next-cycle implication
`define VCM_ASSERT_NXT(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("assertion failed");
`endif

[rtl/vcm_pkg.sv]
// shared constants and types for the center of mass tracker
// no dependencies
`default_nettype none
package vcm_pkg;
	localparam int COORD_BITS   = 12;
	localparam int DENSITY_BITS = 16;
	localparam int FRAC_BITS    = 8;
	localparam int TOTAL_BITS   = 40;
	localparam int WSUM_BITS    = 48;
	localparam int CENTER_BITS  = COORD_BITS + FRAC_BITS;
	localparam int NUM_BITS     = WSUM_BITS + FRAC_BITS;
	localparam int QCNT_BITS    = $clog2(NUM_BITS + 1);
	localparam int FIFO_DEPTH   = 2;
	localparam logic REQ_ADD    = 1'b0;
	localparam logic REQ_REMOVE = 1'b1;

	typedef struct packed {
		logic                           req_type;
		logic signed [COORD_BITS-1:0]   cell_x;
		logic signed [COORD_BITS-1:0]   cell_y;
		logic signed [COORD_BITS-1:0]   cell_z;
		logic        [DENSITY_BITS-1:0] density;
	} req_t;

	typedef struct packed {
		logic signed [CENTER_BITS-1:0] center_x;
		logic signed [CENTER_BITS-1:0] center_y;
		logic signed [CENTER_BITS-1:0] center_z;
		logic                          center_valid;
		logic signed [TOTAL_BITS-1:0]  total_density;
		logic signed [TOTAL_BITS-1:0]  peak_density;
	} rsp_t;

	typedef enum logic [1:0] {
		ST_IDLE, ST_ACC, ST_DIV, ST_DONE
	} back_state_t;
endpackage
`default_nettype wire

[rtl/vcm_if.sv]
// valid/ready channel interface for the tracker
// depends on vcm_pkg
`default_nettype none
interface vcm_req_if;
	logic            valid;
	logic            ready;
	vcm_pkg::req_t   payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface vcm_rsp_if;
	logic            valid;
	logic            ready;
	vcm_pkg::rsp_t   payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

[rtl/vcm_front.sv]
// front part: request queue between input channel and back part
// depends on vcm_pkg
`default_nettype none
module vcm_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire vcm_pkg::req_t in_req,
	output logic               q_valid,
	input  wire logic          q_pop,
	output vcm_pkg::req_t      q_req
);
	localparam int PB = $clog2(vcm_pkg::FIFO_DEPTH);
	vcm_pkg::req_t        mem_q [vcm_pkg::FIFO_DEPTH];
	logic [PB-1:0]        wr_q, rd_q;
	logic [PB:0]          cnt_q;
	logic                 push;

	assign in_ready = (cnt_q != (PB+1)'(vcm_pkg::FIFO_DEPTH));
	assign push     = in_valid && in_ready;
	assign q_valid  = (cnt_q != '0);
	assign q_req    = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= in_req;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (q_pop) rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + (PB+1)'(push) - (PB+1)'(q_pop);
		end
	end
endmodule
`default_nettype wire

[rtl/vcm_divider.sv]
// restoring divider, one quotient bit per cycle, unsigned
// depends on vcm_pkg
`default_nettype none
module vcm_divider (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              start,
	input  wire logic [vcm_pkg::NUM_BITS-1:0]      num,
	input  wire logic [vcm_pkg::TOTAL_BITS-1:0]    den,
	output logic                                   done,
	output logic [vcm_pkg::NUM_BITS-1:0]           quot
);
	localparam int NB = vcm_pkg::NUM_BITS;
	localparam int TB = vcm_pkg::TOTAL_BITS;
	logic [NB-1:0]             quo_q;
	logic [TB:0]               rem_q;
	logic [TB-1:0]             den_q;
	logic [vcm_pkg::QCNT_BITS-1:0] cnt_q;
	logic                      busy_q;
	logic [TB:0]               shifted, diff;

	assign shifted = {rem_q[TB-1:0], quo_q[NB-1]};
	assign diff    = shifted - {1'b0, den_q};
	assign quot    = quo_q;

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			if (!diff[TB]) begin
				rem_q <= diff;
				quo_q <= {quo_q[NB-2:0], 1'b1};
			end else begin
				rem_q <= shifted;
				quo_q <= {quo_q[NB-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= vcm_pkg::QCNT_BITS'(NB);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == vcm_pkg::QCNT_BITS'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end
endmodule
`default_nettype wire

[rtl/vcm_back.sv]
// back part: accumulators, per-axis division sequencing, output register
// depends on vcm_pkg, vcm_divider
`default_nettype none
module vcm_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          q_valid,
	output logic               q_pop,
	input  wire vcm_pkg::req_t q_req,
	output logic               out_valid,
	input  wire logic          out_ready,
	output vcm_pkg::rsp_t      out_rsp
);
	localparam int TB = vcm_pkg::TOTAL_BITS;
	localparam int WB = vcm_pkg::WSUM_BITS;
	localparam int NB = vcm_pkg::NUM_BITS;
	localparam int CB = vcm_pkg::CENTER_BITS;
	localparam int DB = vcm_pkg::DENSITY_BITS;
	localparam int PRB = vcm_pkg::COORD_BITS + DB + 1;

	vcm_pkg::back_state_t state_q, state_d;
	logic signed [TB-1:0] total_q, peak_q;
	logic signed [WB-1:0] wsum_q [3];
	logic [1:0]           axis_q;
	logic signed [CB-1:0] ctr_q [3];
	logic                 rsp_valid_q;
	vcm_pkg::rsp_t        rsp_q;

	logic                 start;
	logic                 div_done;
	logic [NB-1:0]        quot;
	logic signed [WB-1:0] cur_wsum;
	logic                 neg;
	logic [1:0]           div_axis;
	logic signed [WB-1:0] div_wsum;
	logic [WB-1:0]        div_mag;
	logic signed [DB:0]   delta;
	logic signed [PRB-1:0] prod_x, prod_y, prod_z;
	logic signed [TB-1:0] new_total;
	logic                 tot_pos;
	logic signed [CB-1:0] sat_ctr;

	assign delta     = (q_req.req_type == vcm_pkg::REQ_REMOVE) ?
		-$signed({1'b0, q_req.density}) : $signed({1'b0, q_req.density});
	assign prod_x    = q_req.cell_x * delta;
	assign prod_y    = q_req.cell_y * delta;
	assign prod_z    = q_req.cell_z * delta;
	assign new_total = total_q + TB'(delta);
	assign tot_pos   = !total_q[TB-1] && (total_q != '0);
	// sign of the axis whose quotient is coming back
	assign cur_wsum  = wsum_q[axis_q];
	assign neg       = cur_wsum[WB-1];
	// axis whose division is being started
	assign div_axis  = (state_q == vcm_pkg::ST_ACC || axis_q == 2'd2) ? 2'd0 :
		axis_q + 2'd1;
	assign div_wsum  = wsum_q[div_axis];
	assign div_mag   = div_wsum[WB-1] ? WB'(-div_wsum) : WB'(div_wsum);

	vcm_divider u_div (
		.clk(clk), .arst_n(arst_n), .start(start),
		.num({div_mag, {vcm_pkg::FRAC_BITS{1'b0}}}),
		.den(TB'(total_q)), .done(div_done), .quot(quot)
	);

	// saturate quotient into the signed center field
	always_comb begin
		if (neg) begin
			if (quot > NB'({1'b1, {(CB-1){1'b0}}})) sat_ctr = {1'b1, {(CB-1){1'b0}}};
			else sat_ctr = CB'(-quot);
		end else begin
			if (quot > NB'({1'b0, {(CB-1){1'b1}}})) sat_ctr = {1'b0, {(CB-1){1'b1}}};
			else sat_ctr = CB'(quot);
		end
	end

	always_comb begin
		state_d = state_q;
		q_pop   = 1'b0;
		start   = 1'b0;
		unique case (state_q)
			vcm_pkg::ST_IDLE: begin
				if (q_valid) begin
					q_pop   = 1'b1;
					state_d = vcm_pkg::ST_ACC;
				end
			end
			vcm_pkg::ST_ACC: begin
				if (tot_pos) begin
					start   = 1'b1;
					state_d = vcm_pkg::ST_DIV;
				end else begin
					state_d = vcm_pkg::ST_DONE;
				end
			end
			vcm_pkg::ST_DIV: begin
				if (div_done) begin
					if (axis_q == 2'd2) state_d = vcm_pkg::ST_DONE;
					else start = 1'b1;
				end
			end
			vcm_pkg::ST_DONE: begin
				if (!rsp_valid_q || out_ready) state_d = vcm_pkg::ST_IDLE;
			end
			default: state_d = vcm_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == vcm_pkg::ST_DIV && div_done) ctr_q[axis_q] <= sat_ctr;
		if (state_q == vcm_pkg::ST_DONE && (!rsp_valid_q || out_ready)) begin
			rsp_q.center_x      <= tot_pos ? ctr_q[0] : '0;
			rsp_q.center_y      <= tot_pos ? ctr_q[1] : '0;
			rsp_q.center_z      <= tot_pos ? ctr_q[2] : '0;
			rsp_q.center_valid  <= tot_pos;
			rsp_q.total_density <= total_q;
			rsp_q.peak_density  <= peak_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= vcm_pkg::ST_IDLE;
			total_q     <= '0;
			peak_q      <= '0;
			wsum_q[0]   <= '0;
			wsum_q[1]   <= '0;
			wsum_q[2]   <= '0;
			axis_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == vcm_pkg::ST_IDLE && q_valid) begin
				total_q   <= new_total;
				wsum_q[0] <= wsum_q[0] + WB'(prod_x);
				wsum_q[1] <= wsum_q[1] + WB'(prod_y);
				wsum_q[2] <= wsum_q[2] + WB'(prod_z);
				if (q_req.req_type == vcm_pkg::REQ_ADD && new_total > peak_q)
					peak_q <= new_total;
			end
			if (start) begin
				if (state_q == vcm_pkg::ST_ACC) axis_q <= '0;
				else axis_q <= axis_q + 1'b1;
			end
			if (state_q == vcm_pkg::ST_DONE && (!rsp_valid_q || out_ready))
				rsp_valid_q <= 1'b1;
			else if (out_ready)
				rsp_valid_q <= 1'b0;
		end
	end

	assign out_valid = rsp_valid_q;
	assign out_rsp   = rsp_q;
endmodule
`default_nettype wire

[rtl/voxel_center_of_mass_tracker.sv]
// center of mass tracker: per request, three 56-bit divisions on one radix-2 divider
// when the total is positive, none otherwise
// one request is processed at a time; a two-entry queue takes requests meanwhile
// asynchronous active-low reset clears totals, sums, peak and all handshake state
`default_nettype none
module voxel_center_of_mass_tracker (
	input  wire logic  clk,
	input  wire logic  arst_n,
	vcm_req_if.sink    in_ch,
	vcm_rsp_if.source  out_ch
);
	// queue toward the back part
	logic          q_valid;
	logic          q_pop;
	vcm_pkg::req_t q_req;

	vcm_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_req(in_ch.payload),
		.q_valid(q_valid), .q_pop(q_pop), .q_req(q_req)
	);

	// accumulate, divide per axis, register the result
	vcm_back u_back (
		.clk(clk), .arst_n(arst_n),
		.q_valid(q_valid), .q_pop(q_pop), .q_req(q_req),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_rsp(out_ch.payload)
	);
endmodule
`default_nettype wire

[rtl/vcm_checker.sv]
// port-level checker for the tracker, bound to the top level
// depends on vcm_pkg and the assertion macro header
`default_nettype none
`include "voxel_center_of_mass_tracker_assert.svh"
module vcm_checker (
	input wire logic          clk,
	input wire logic          arst_n,
	input wire logic          out_valid,
	input wire logic          out_ready,
	input wire vcm_pkg::rsp_t out_rsp
);
	`VCM_ASSERT_IMP(a_zero_center, clk, arst_n, out_valid && !out_rsp.center_valid, out_rsp.center_x == '0 && out_rsp.center_y == '0 && out_rsp.center_z == '0)
	`VCM_ASSERT_IMP(a_valid_pos, clk, arst_n, out_valid, out_rsp.center_valid == (!out_rsp.total_density[vcm_pkg::TOTAL_BITS-1] && out_rsp.total_density != '0))
	`VCM_ASSERT_NXT(a_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_rsp))
endmodule

bind voxel_center_of_mass_tracker vcm_checker u_chk (
	.clk(clk), .arst_n(arst_n), .out_valid(out_ch.valid),
	.out_ready(out_ch.ready), .out_rsp(out_ch.payload)
);
`default_nettype wire

[tb/sv/voxel_center_of_mass_tracker_test.sv]
// self-checking testbench for the voxel center of mass tracker
// depends on vcm_pkg and the vcm_req_if / vcm_rsp_if channel interfaces
`default_nettype none
module voxel_center_of_mass_tracker_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LIMIT_CYCLES = 900000;
	localparam int DRAIN_CYCLES = 400;
	localparam int TBITS = vcm_pkg::TOTAL_BITS;
	localparam int WBITS = vcm_pkg::WSUM_BITS;
	localparam int CBITS = vcm_pkg::CENTER_BITS;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	always #2 clk = ~clk;

	vcm_req_if req_ch ();
	vcm_rsp_if rsp_ch ();

	voxel_center_of_mass_tracker dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(req_ch.sink),
		.out_ch(rsp_ch.source)
	);

	// tracked body: running totals mirrored from the block's behavior
	logic signed [TBITS-1:0] body_total;
	logic signed [WBITS-1:0] body_sum_x, body_sum_y, body_sum_z;
	logic signed [TBITS-1:0] body_peak;

	vcm_pkg::rsp_t expected_centers[$];
	int   error_count = 0;
	int   cycle_count = 0;

	// idle / stall percentages per phase
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	bit hold_off = 1'b0;

	// one signed axis center, truncated toward zero and saturated
	function automatic logic signed [CBITS-1:0] axis_center(
		input logic signed [WBITS-1:0] wsum,
		input logic signed [TBITS-1:0] total);
		logic [63:0] mag;
		logic [63:0] quot;
		logic [63:0] pos_lim;
		logic [63:0] neg_lim;
		mag = wsum[WBITS-1] ? 64'(-$signed(64'(wsum))) : 64'(wsum);
		quot = (mag << vcm_pkg::FRAC_BITS) / 64'(total);
		pos_lim = (64'd1 << (CBITS - 1)) - 64'd1;
		neg_lim = 64'd1 << (CBITS - 1);
		if (wsum[WBITS-1]) begin
			if (quot > neg_lim)
				quot = neg_lim;
			return CBITS'(-quot);
		end
		if (quot > pos_lim)
			quot = pos_lim;
		return CBITS'(quot);
	endfunction

	// apply one voxel edit and return the center of mass it leaves
	function automatic vcm_pkg::rsp_t apply_voxel(input vcm_pkg::req_t r);
		vcm_pkg::rsp_t res;
		logic signed [WBITS-1:0] delta;
		delta = (r.req_type == vcm_pkg::REQ_REMOVE) ? -$signed({32'd0, r.density})
			: $signed({32'd0, r.density});
		body_total = body_total + TBITS'(delta);
		body_sum_x = body_sum_x + WBITS'(r.cell_x) * delta;
		body_sum_y = body_sum_y + WBITS'(r.cell_y) * delta;
		body_sum_z = body_sum_z + WBITS'(r.cell_z) * delta;
		if (r.req_type == vcm_pkg::REQ_ADD && body_total > body_peak)
			body_peak = body_total;
		res = '0;
		res.center_valid = body_total > 0;
		if (res.center_valid) begin
			res.center_x = axis_center(body_sum_x, body_total);
			res.center_y = axis_center(body_sum_y, body_total);
			res.center_z = axis_center(body_sum_z, body_total);
		end
		res.total_density = body_total;
		res.peak_density = body_peak;
		return res;
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
		input logic [63:0] want);
		error_count++;
		$display("mismatch %s: got %0h want %0h at cycle %0d", what, got, want, cycle_count);
	endtask

	// response checker: compares every accepted response with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (expected_centers.size() == 0) begin
				report_mismatch("unexpected response", 64'(rsp_ch.payload.total_density), 0);
			end else begin
				vcm_pkg::rsp_t want;
				vcm_pkg::rsp_t got;
				want = expected_centers.pop_front();
				got = rsp_ch.payload;
				if (got.center_x !== want.center_x)
					report_mismatch("center_x", 64'(got.center_x), 64'(want.center_x));
				if (got.center_y !== want.center_y)
					report_mismatch("center_y", 64'(got.center_y), 64'(want.center_y));
				if (got.center_z !== want.center_z)
					report_mismatch("center_z", 64'(got.center_z), 64'(want.center_z));
				if (got.center_valid !== want.center_valid)
					report_mismatch("center_valid", 64'(got.center_valid),
						64'(want.center_valid));
				if (got.total_density !== want.total_density)
					report_mismatch("total_density", 64'(got.total_density),
						64'(want.total_density));
				if (got.peak_density !== want.peak_density)
					report_mismatch("peak_density", 64'(got.peak_density),
						64'(want.peak_density));
			end
		end
	end

	// receiver: random stalls, plus a long hold-off when asked
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else begin
			rsp_ch.ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// long hold-off counted in its own process
	task automatic hold_receiver(input int cycles);
		hold_off = 1'b1;
		repeat (cycles) @(posedge clk);
		hold_off = 1'b0;
	endtask

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// drive one request: optional idle gaps, then hold valid until accepted
	task automatic send_voxel(input vcm_pkg::req_t r);
		while ($urandom_range(99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.payload <= r;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		expected_centers.push_back(apply_voxel(r));
	endtask

	function automatic vcm_pkg::req_t random_voxel();
		vcm_pkg::req_t r;
		r.req_type = ($urandom_range(99) < 30) ? vcm_pkg::REQ_REMOVE : vcm_pkg::REQ_ADD;
		case ($urandom_range(3))
			0: r.cell_x = vcm_pkg::COORD_BITS'($urandom);
			1: r.cell_x = $urandom_range(1) ? 12'sh7ff : 12'sh800;
			default: r.cell_x = vcm_pkg::COORD_BITS'($signed($urandom_range(64)) - 32);
		endcase
		r.cell_y = vcm_pkg::COORD_BITS'($urandom);
		r.cell_z = $urandom_range(3) == 0 ? vcm_pkg::COORD_BITS'($urandom)
			: vcm_pkg::COORD_BITS'($signed($urandom_range(200)) - 100);
		case ($urandom_range(3))
			0: r.density = vcm_pkg::DENSITY_BITS'($urandom);
			1: r.density = $urandom_range(1) ? 16'hffff : 16'h0000;
			default: r.density = vcm_pkg::DENSITY_BITS'($urandom_range(1024));
		endcase
		return r;
	endfunction

	// directed table: type, x, y, z, density; checked by the predictor,
	// with hand-typed totals/flags on the rows where they are plain
	typedef struct {
		vcm_pkg::req_t r;
		bit   typed;
		logic signed [TBITS-1:0] total;
		logic signed [TBITS-1:0] peak;
		logic valid;
	} voxel_row_t;

	voxel_row_t directed_rows[] = '{
		// zero density on an empty body: center invalid
		'{'{vcm_pkg::REQ_ADD, 12'sd0, 12'sd0, 12'sd0, 16'h0000}, 1, 40'sd0, 40'sd0, 1'b0},
		// single unit voxel at origin
		'{'{vcm_pkg::REQ_ADD, 12'sd0, 12'sd0, 12'sd0, 16'h0100}, 1, 40'sd256, 40'sd256,
			1'b1},
		// extremes of the coordinate range
		'{'{vcm_pkg::REQ_ADD, 12'sh7ff, 12'sh800, 12'sh7ff, 16'hffff}, 0, 0, 0, 0},
		'{'{vcm_pkg::REQ_ADD, 12'sh800, 12'sh7ff, 12'sh800, 16'h0001}, 0, 0, 0, 0},
		'{'{vcm_pkg::REQ_REMOVE, 12'sh7ff, 12'sh800, 12'sh7ff, 16'hffff}, 0, 0, 0, 0},
		'{'{vcm_pkg::REQ_REMOVE, 12'sh800, 12'sh7ff, 12'sh800, 16'h0001}, 0, 0, 0, 0},
		// back to empty: total zero, peak stays
		'{'{vcm_pkg::REQ_REMOVE, 12'sd0, 12'sd0, 12'sd0, 16'h0100}, 1, 40'sd0, 40'sd65792,
			1'b0},
		// remove past empty: negative total, peak unchanged
		'{'{vcm_pkg::REQ_REMOVE, 12'sd5, 12'sd5, 12'sd5, 16'hffff}, 1, -40'sd65535,
			40'sd65792, 1'b0},
		'{'{vcm_pkg::REQ_ADD, 12'sd5, 12'sd5, 12'sd5, 16'hffff}, 1, 40'sd0, 40'sd65792,
			1'b0},
		// saturation: tiny mass with far voxels cancelled by a large opposite sum
		'{'{vcm_pkg::REQ_ADD, 12'sh7ff, 12'sh7ff, 12'sh800, 16'hffff}, 0, 0, 0, 0},
		'{'{vcm_pkg::REQ_REMOVE, 12'sd0, 12'sd0, 12'sd0, 16'hfffe}, 0, 0, 0, 0},
		'{'{vcm_pkg::REQ_ADD, 12'sh800, 12'sh800, 12'sh7ff, 16'h0001}, 0, 0, 0, 0},
		// truncation toward zero with negative and positive sums
		'{'{vcm_pkg::REQ_ADD, -12'sd3, 12'sd3, -12'sd1, 16'h0003}, 0, 0, 0, 0},
		'{'{vcm_pkg::REQ_ADD, 12'sd1, -12'sd2, 12'sd7, 16'h0007}, 0, 0, 0, 0},
		'{'{vcm_pkg::REQ_REMOVE, 12'sh7ff, 12'sh7ff, 12'sh800, 16'hffff}, 0, 0, 0, 0},
		'{'{vcm_pkg::REQ_ADD, 12'sd100, -12'sd100, 12'sd0, 16'h8000}, 0, 0, 0, 0},
		'{'{vcm_pkg::REQ_ADD, 12'sh555, 12'shaaa, 12'sh333, 16'h5555}, 0, 0, 0, 0},
		'{'{vcm_pkg::REQ_ADD, 12'shaaa, 12'sh555, 12'shccc, 16'haaaa}, 0, 0, 0, 0}
	};

	initial begin
		int sent;
		int phase;
		req_ch.valid = 1'b0;
		req_ch.payload = '0;
		body_total = '0;
		body_sum_x = '0;
		body_sum_y = '0;
		body_sum_z = '0;
		body_peak = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			send_voxel(directed_rows[i].r);
			// hand-typed rows override the predictor's numbers with known ones
			if (directed_rows[i].typed) begin
				vcm_pkg::rsp_t known;
				known = expected_centers.pop_back();
				if (known.total_density !== directed_rows[i].total ||
					known.peak_density !== directed_rows[i].peak ||
					known.center_valid !== directed_rows[i].valid)
					report_mismatch("directed row", 64'(i), 64'(known.total_density));
				known.total_density = directed_rows[i].total;
				known.peak_density = directed_rows[i].peak;
				known.center_valid = directed_rows[i].valid;
				expected_centers.push_back(known);
			end
		end

		// random phases with varied idling; a long receiver hold-off in phase one
		for (phase = 0; phase < 5; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				2: begin send_idle_pct = 63; recv_stall_pct = 0;  end
				3: begin send_idle_pct = 0;  recv_stall_pct = 63; end
				default: begin send_idle_pct = 20; recv_stall_pct = 20; end
			endcase
			if (phase == 1)
				fork
					hold_receiver(2000);
				join_none
			for (sent = 0; sent < 140; sent++)
				send_voxel(random_voxel());
		end
		req_ch.valid <= 1'b0;

		while (expected_centers.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule
`default_nettype wire

[voxel_center_of_mass_tracker.f]
+incdir+rtl
rtl/vcm_pkg.sv
rtl/vcm_if.sv
rtl/vcm_front.sv
rtl/vcm_divider.sv
rtl/vcm_back.sv
rtl/voxel_center_of_mass_tracker.sv
rtl/vcm_checker.sv
tb/sv/voxel_center_of_mass_tracker_test.sv
